/* design/rrts_pkg.sv */
// ============================================================================
// rrts_pkg
// Shared types and constants for the round-robin time-slice scheduler.
// ============================================================================
package rrts_pkg;

    // Default sizing
    localparam int MAX_PROCS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    // Fixed field widths
    localparam int INDEX_W = 4;
    localparam int FIELD_W = 16;
    localparam int KIND_W  = 2;
    localparam int QUANT_W = 8;
    localparam int COUNT_W = 5;

    // Stream packing
    localparam int S_TDATA_W = 40;  // index + arrival + burst, padded to bytes
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = 56;  // process + time + turnaround + waiting + all_done
    localparam int M_TUSER_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 1'd1;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_CHK,
        S_POP,
        S_POP_CHK,
        S_RUN,
        S_SCAN,
        S_POST,
        S_WAIT_CALC,
        S_OUT
    } state_t;

endpackage

/* design/round_robin_time_slice_scheduler.sv */
// Flow: a load beat is written on acceptance; a start beat scans the n process
// entries in use. A tick beat passes the tick read, check, optional pop, run,
// scan, post, optional waiting calculation and output states. One beat is taken
// at a time; the table scan reads one entry per cycle through the single read port.
// Reset: rst_n clears clock, queue pointers and running state; tables and the
// ready queue hold undefined data until written. Quantum resets to 1.
// ============================================================================
// round_robin_time_slice_scheduler
// Tick-driven round-robin scheduler with one configurable time quantum. A small
// sequencer drives one shared subtract unit and one table read port.
// ============================================================================
module round_robin_time_slice_scheduler #(
    parameter int MAX_PROCS = rrts_pkg::MAX_PROCS_DEF,
    parameter int TIME_BITS = rrts_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rrts_pkg::S_TDATA_W-1:0]   s_tdata,   // process_index, arrival_time, burst_length
    input  logic [rrts_pkg::S_TUSER_W-1:0]   s_tuser,   // kind
    // master side
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rrts_pkg::M_TDATA_W-1:0]   m_tdata,   // slot_process, slot_time, turnaround, waiting, all_done
    output logic [rrts_pkg::M_TUSER_W-1:0]   m_tuser,   // slot_idle, finished
    // configuration
    input  logic                             cfg_we,
    input  logic [rrts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rrts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rrts_pkg::*;

    localparam int ID_W  = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int AW    = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;

    // ------------------------------------------------------------------
    // Beat fields
    // ------------------------------------------------------------------
    logic [INDEX_W-1:0] in_index;
    logic [FIELD_W-1:0] in_arrival;
    logic [FIELD_W-1:0] in_burst;
    logic [KIND_W-1:0]  in_kind;
    logic               in_accept;

    assign in_index   = s_tdata[INDEX_W-1:0];
    assign in_arrival = s_tdata[INDEX_W +: FIELD_W];
    assign in_burst   = s_tdata[INDEX_W+FIELD_W +: FIELD_W];
    assign in_kind    = s_tuser;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t               state_reg, state_next;
    logic [TIME_BITS-1:0] clock_reg, clock_next;
    logic [ID_W-1:0]      head_reg, head_next;
    logic [ID_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic                 run_valid_reg, run_valid_next;
    logic [ID_W-1:0]      run_id_reg, run_id_next;
    logic [QUANT_W-1:0]   slice_reg, slice_next;
    logic [QUANT_W-1:0]   quantum_reg, quantum_next;
    logic [COUNT_W-1:0]   pcount_reg, pcount_next;
    logic [CNT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                 scan_pend_reg, scan_pend_next;
    logic [ID_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                 scan_start_reg, scan_start_next;
    logic                 adv_reg, adv_next;
    logic                 done_reg, done_next;
    logic                 ran_reg, ran_next;
    logic                 fin_reg, fin_next;
    logic                 out_valid_reg, out_valid_next;

    // payload registers
    logic [AW-1:0]        slot_time_reg, slot_time_next;
    logic [FIELD_W-1:0]   run_arr_reg, run_arr_next;
    logic [FIELD_W-1:0]   run_burst_reg, run_burst_next;
    logic [AW-1:0]        tat_reg, tat_next;
    logic [AW-1:0]        wt_reg, wt_next;
    logic                 o_idle_reg, o_idle_next;
    logic [INDEX_W-1:0]   o_proc_reg, o_proc_next;
    logic [FIELD_W-1:0]   o_time_reg, o_time_next;
    logic                 o_fin_reg, o_fin_next;
    logic [FIELD_W-1:0]   o_tat_reg, o_tat_next;
    logic [FIELD_W-1:0]   o_wt_reg, o_wt_next;
    logic                 o_done_reg, o_done_next;

    // ------------------------------------------------------------------
    // Memories and their read registers
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0] arr_mem   [MAX_PROCS];
    logic [FIELD_W-1:0] burst_mem [MAX_PROCS];
    logic [FIELD_W-1:0] rem_mem   [MAX_PROCS];
    logic [ID_W-1:0]    fifo_mem  [MAX_PROCS];

    logic [FIELD_W-1:0] rd_arr_reg;
    logic [FIELD_W-1:0] rd_burst_reg;
    logic [FIELD_W-1:0] rd_rem_reg;
    logic [ID_W-1:0]    fifo_rd_reg;

    logic               tbl_re;
    logic [ID_W-1:0]    tbl_raddr;
    logic               load_we;
    logic [ID_W-1:0]    load_addr;
    logic               rem_we;
    logic [ID_W-1:0]    rem_waddr;
    logic [FIELD_W-1:0] rem_wdata;
    logic               fifo_re;
    logic               fifo_we;
    logic               push_req;
    logic [ID_W-1:0]    push_id;

    // ------------------------------------------------------------------
    // Helper terms
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   n_use;
    logic [QUANT_W-1:0] q_eff;
    logic               chk_keep;
    logic               need_pop;
    logic               scan_more;
    logic               scan_end;
    logic               clk_max;
    logic               out_free;
    logic               fifo_full;
    logic               rd_rem_nz;
    logic [31:0]        idx_ext;
    logic [31:0]        run_id_ext;
    logic [QUANT_W:0]   slice_inc;

    assign n_use = (CMP_W'(pcount_reg) > CMP_W'(MAX_PROCS)) ? CNT_W'(MAX_PROCS)
                                                            : CNT_W'(pcount_reg);
    assign q_eff      = (quantum_reg == '0) ? QUANT_W'(1) : quantum_reg;
    assign rd_rem_nz  = (rd_rem_reg != '0);
    assign chk_keep   = run_valid_reg && rd_rem_nz;
    assign need_pop   = !chk_keep && (fill_reg != '0);
    assign scan_more  = (scan_cnt_reg < n_use);
    assign scan_end   = !scan_more && !scan_pend_reg;
    assign clk_max    = &clock_reg;
    assign out_free   = !out_valid_reg || m_tready;
    assign fifo_full  = (fill_reg == CNT_W'(MAX_PROCS));
    assign idx_ext    = 32'(in_index);
    assign load_addr  = idx_ext[ID_W-1:0];
    assign run_id_ext = 32'(run_id_reg);
    assign slice_inc  = {1'b0, slice_reg} + (QUANT_W+1)'(1);
    assign in_accept  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Shared saturating subtract unit
    // ------------------------------------------------------------------
    logic [AW-1:0] alu_a;
    logic [AW-1:0] alu_b;
    logic [AW:0]   alu_diff;
    logic [AW-1:0] alu_res;

    always_comb
    begin
        case (state_reg)
            S_RUN:
            begin
                alu_a = AW'(rd_rem_reg);
                alu_b = AW'(1);
            end
            S_POST:
            begin
                alu_a = AW'(clock_reg);
                alu_b = AW'(run_arr_reg);
            end
            S_WAIT_CALC:
            begin
                alu_a = tat_reg;
                alu_b = AW'(run_burst_reg);
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_res  = alu_diff[AW] ? '0 : alu_diff[AW-1:0];

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_kind)
                        KIND_START: state_next = S_SCAN;
                        KIND_TICK:  state_next = S_TICK_RD;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_TICK_RD:   state_next = S_TICK_CHK;
            S_TICK_CHK:  state_next = need_pop ? S_POP : S_RUN;
            S_POP:       state_next = S_POP_CHK;
            S_POP_CHK:   state_next = S_RUN;
            S_RUN:       state_next = S_SCAN;
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = scan_start_reg ? S_IDLE : S_POST;
                end
            end
            S_POST:      state_next = (ran_reg && fin_reg) ? S_WAIT_CALC : S_OUT;
            S_WAIT_CALC: state_next = S_OUT;
            S_OUT:       state_next = out_free ? S_IDLE : S_OUT;
            default:     state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory controls
    // ------------------------------------------------------------------
    always_comb
    begin
        clock_next      = clock_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        run_valid_next  = run_valid_reg;
        run_id_next     = run_id_reg;
        slice_next      = slice_reg;
        quantum_next    = quantum_reg;
        pcount_next     = pcount_reg;
        scan_cnt_next   = scan_cnt_reg;
        scan_pend_next  = scan_pend_reg;
        scan_idx_next   = scan_idx_reg;
        scan_start_next = scan_start_reg;
        adv_next        = adv_reg;
        done_next       = done_reg;
        ran_next        = ran_reg;
        fin_next        = fin_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        slot_time_next  = slot_time_reg;
        run_arr_next    = run_arr_reg;
        run_burst_next  = run_burst_reg;
        tat_next        = tat_reg;
        wt_next         = wt_reg;
        o_idle_next     = o_idle_reg;
        o_proc_next     = o_proc_reg;
        o_time_next     = o_time_reg;
        o_fin_next      = o_fin_reg;
        o_tat_next      = o_tat_reg;
        o_wt_next       = o_wt_reg;
        o_done_next     = o_done_reg;

        tbl_re    = 1'b0;
        tbl_raddr = run_id_reg;
        load_we   = 1'b0;
        rem_we    = 1'b0;
        rem_waddr = run_id_reg;
        rem_wdata = alu_res[FIELD_W-1:0];
        fifo_re   = 1'b0;
        push_req  = 1'b0;
        push_id   = run_id_reg;

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                REG_QUANTUM: quantum_next = cfg_wdata[QUANT_W-1:0];
                REG_COUNT:   pcount_next  = cfg_wdata[COUNT_W-1:0];
                default:     quantum_next = quantum_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_kind)
                        KIND_LOAD:
                        begin
                            if (idx_ext < 32'(MAX_PROCS))
                            begin
                                load_we   = 1'b1;
                                rem_we    = 1'b1;
                                rem_waddr = load_addr;
                                rem_wdata = in_burst;
                            end
                        end
                        KIND_START:
                        begin
                            clock_next      = '0;
                            head_next       = '0;
                            tail_next       = '0;
                            fill_next       = '0;
                            run_valid_next  = 1'b0;
                            run_id_next     = '0;
                            slice_next      = '0;
                            scan_start_next = 1'b1;
                            scan_cnt_next   = '0;
                            scan_pend_next  = 1'b0;
                        end
                        KIND_TICK:
                        begin
                            tbl_re    = 1'b1;
                            tbl_raddr = run_id_reg;
                        end
                        default:
                        begin
                            tbl_re = 1'b0;
                        end
                    endcase
                end
            end

            // drop a stale running process, fetch the queue head if needed
            S_TICK_CHK:
            begin
                run_valid_next = chk_keep;
                fifo_re        = need_pop;
            end

            S_POP:
            begin
                run_id_next = fifo_rd_reg;
                head_next   = (head_reg == ID_W'(MAX_PROCS - 1)) ? '0 : head_reg + ID_W'(1);
                fill_next   = fill_reg - CNT_W'(1);
                slice_next  = '0;
                tbl_re      = 1'b1;
                tbl_raddr   = fifo_rd_reg;
            end

            S_POP_CHK:
            begin
                run_valid_next = rd_rem_nz;
            end

            // run one unit if a process is running, and advance the clock unless saturated
            S_RUN:
            begin
                ran_next        = run_valid_reg;
                fin_next        = run_valid_reg && (alu_res == '0);
                slot_time_next  = AW'(clock_reg);
                run_arr_next    = rd_arr_reg;
                run_burst_next  = rd_burst_reg;
                rem_we          = run_valid_reg;
                rem_waddr       = run_id_reg;
                rem_wdata       = alu_res[FIELD_W-1:0];
                adv_next        = !clk_max;
                if (!clk_max)
                begin
                    clock_next = clock_reg + TIME_BITS'(1);
                end
                scan_start_next = 1'b0;
                scan_cnt_next   = '0;
                scan_pend_next  = 1'b0;
                done_next       = 1'b1;
            end

            // one entry read per cycle, evaluated in the cycle after its read
            S_SCAN:
            begin
                scan_pend_next = scan_more;
                if (scan_more)
                begin
                    tbl_re        = 1'b1;
                    tbl_raddr     = scan_cnt_reg[ID_W-1:0];
                    scan_idx_next = scan_cnt_reg[ID_W-1:0];
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                if (scan_pend_reg)
                begin
                    push_id = scan_idx_reg;
                    if (scan_start_reg)
                    begin
                        rem_we    = 1'b1;
                        rem_waddr = scan_idx_reg;
                        rem_wdata = rd_burst_reg;
                        push_req  = (rd_arr_reg == '0) && (rd_burst_reg != '0);
                    end
                    else
                    begin
                        push_req = adv_reg && rd_rem_nz
                                   && (AW'(rd_arr_reg) == AW'(clock_reg));
                        if (rd_rem_nz)
                        begin
                            done_next = 1'b0;
                        end
                    end
                end
            end

            // retire, requeue at the quantum or keep running, after the arrivals
            S_POST:
            begin
                tat_next = '0;
                wt_next  = '0;
                if (ran_reg)
                begin
                    if (fin_reg)
                    begin
                        run_valid_next = 1'b0;
                        tat_next       = alu_res;
                    end
                    else
                    begin
                        slice_next = slice_inc[QUANT_W-1:0];
                        if (slice_inc >= {1'b0, q_eff})
                        begin
                            run_valid_next = 1'b0;
                            push_req       = 1'b1;
                            push_id        = run_id_reg;
                        end
                    end
                end
            end

            S_WAIT_CALC:
            begin
                wt_next = alu_res;
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_idle_next    = !ran_reg;
                    o_proc_next    = ran_reg ? run_id_ext[INDEX_W-1:0] : '0;
                    o_time_next    = slot_time_reg[FIELD_W-1:0];
                    o_fin_next     = fin_reg;
                    o_tat_next     = tat_reg[FIELD_W-1:0];
                    o_wt_next      = wt_reg[FIELD_W-1:0];
                    o_done_next    = done_reg;
                end
            end

            default:
            begin
                tbl_re = 1'b0;
            end
        endcase

        // ready queue push, dropped when full
        fifo_we = push_req && !fifo_full;
        if (fifo_we)
        begin
            tail_next = (tail_reg == ID_W'(MAX_PROCS - 1)) ? '0 : tail_reg + ID_W'(1);
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            clock_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            run_valid_reg  <= 1'b0;
            run_id_reg     <= '0;
            slice_reg      <= '0;
            quantum_reg    <= QUANT_W'(1);
            pcount_reg     <= '0;
            scan_cnt_reg   <= '0;
            scan_pend_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            scan_start_reg <= 1'b0;
            adv_reg        <= 1'b0;
            done_reg       <= 1'b0;
            ran_reg        <= 1'b0;
            fin_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clock_reg      <= clock_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            run_valid_reg  <= run_valid_next;
            run_id_reg     <= run_id_next;
            slice_reg      <= slice_next;
            quantum_reg    <= quantum_next;
            pcount_reg     <= pcount_next;
            scan_cnt_reg   <= scan_cnt_next;
            scan_pend_reg  <= scan_pend_next;
            scan_idx_reg   <= scan_idx_next;
            scan_start_reg <= scan_start_next;
            adv_reg        <= adv_next;
            done_reg       <= done_next;
            ran_reg        <= ran_next;
            fin_reg        <= fin_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        slot_time_reg <= slot_time_next;
        run_arr_reg   <= run_arr_next;
        run_burst_reg <= run_burst_next;
        tat_reg       <= tat_next;
        wt_reg        <= wt_next;
        o_idle_reg    <= o_idle_next;
        o_proc_reg    <= o_proc_next;
        o_time_reg    <= o_time_next;
        o_fin_reg     <= o_fin_next;
        o_tat_reg     <= o_tat_next;
        o_wt_reg      <= o_wt_next;
        o_done_reg    <= o_done_next;
    end

    // ------------------------------------------------------------------
    // Process tables: one read port, load and remaining write ports
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            arr_mem[load_addr]   <= in_arrival;
            burst_mem[load_addr] <= in_burst;
        end
        if (rem_we)
        begin
            rem_mem[rem_waddr] <= rem_wdata;
        end
        if (tbl_re)
        begin
            rd_arr_reg   <= arr_mem[tbl_raddr];
            rd_burst_reg <= burst_mem[tbl_raddr];
            rd_rem_reg   <= rem_mem[tbl_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Ready queue storage
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[tail_reg] <= push_id;
        end
        if (fifo_re)
        begin
            fifo_rd_reg <= fifo_mem[head_reg];
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {o_fin_reg, o_idle_reg};
    assign m_tdata  = {3'b000, o_done_reg, o_wt_reg, o_tat_reg, o_time_reg, o_proc_reg};

endmodule

/* test/tb_round_robin_time_slice_scheduler.sv */
// ============================================================================
// tb_round_robin_time_slice_scheduler
// Self-checking bench for the tick-driven round-robin scheduler. A cycle-free
// scheduler model runs beside the block and predicts one slot beat per tick.
// Directed tests hit the corner cases: full ready queue, stale and zero-burst
// entries, loads during a schedule, negative differences and a late arrival.
// Random schedules follow under four idle/stall mixes.
// ============================================================================
module tb_round_robin_time_slice_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import rrts_pkg::*;

    localparam int NPROC         = MAX_PROCS_DEF;
    localparam int SETTLE_CYCLES = 40;     // covers the longest tick or start
    localparam int STALL_LIMIT   = 4000;   // cycles with no beat on either side
    localparam int MAX_PRINTS    = 40;
    localparam int RANDOM_BEATS  = 900;
    localparam int TICK_CAP      = 150;    // upper bound on ticks per random schedule
    localparam int LATE_TICKS    = 48;     // idle stretch, admission and the full run
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // One slot beat as the checker sees it
    typedef struct packed {
        logic               slot_idle;
        logic [INDEX_W-1:0] slot_process;
        logic [FIELD_W-1:0] slot_time;
        logic               finished;
        logic [FIELD_W-1:0] turnaround;
        logic [FIELD_W-1:0] waiting;
        logic               all_done;
    } slot_rec_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;      // process_index, arrival_time, burst_length
    logic [S_TUSER_W-1:0]  s_tuser   = KIND_LOAD; // kind
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;             // slot_process, slot_time, turnaround,
                                                // waiting, all_done
    logic [M_TUSER_W-1:0]  m_tuser;             // slot_idle, finished
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_QUANTUM;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Scheduler model state
    logic [FIELD_W-1:0] arrival_mem [NPROC];
    logic [FIELD_W-1:0] burst_mem   [NPROC];
    logic [FIELD_W-1:0] left_mem    [NPROC];
    logic [INDEX_W-1:0] ready_q_mem [NPROC];
    int unsigned        rq_head     = 0;
    int unsigned        rq_tail     = 0;
    int unsigned        rq_fill     = 0;
    logic [FIELD_W-1:0] sched_clock = '0;
    bit                 running     = 1'b0;
    logic [INDEX_W-1:0] running_pid = '0;
    int unsigned        slice_count = 0;
    logic [QUANT_W-1:0] quantum_reg = 8'd1;
    logic [COUNT_W-1:0] count_reg   = '0;
    bit                 predicted_all_done = 1'b1;

    slot_rec_t expected_slots [$];
    int        error_count = 0;
    int        gap_pct     = 0;
    int        stall_pct   = 0;
    int        beats_sent  = 0;

    round_robin_time_slice_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Scheduler model
    // ------------------------------------------------------------------------
    function automatic int unsigned entries_in_use();
        return (count_reg > NPROC) ? NPROC : count_reg;
    endfunction

    // enqueue into a full queue is dropped
    function automatic void ready_push(logic [INDEX_W-1:0] pid);
        if (rq_fill >= NPROC)
            return;
        ready_q_mem[rq_tail] = pid;
        rq_tail = (rq_tail + 1) % NPROC;
        rq_fill++;
    endfunction

    function automatic logic [INDEX_W-1:0] ready_pop();
        logic [INDEX_W-1:0] pid;
        pid = ready_q_mem[rq_head];
        rq_head = (rq_head + 1) % NPROC;
        rq_fill--;
        return pid;
    endfunction

    // arrivals at time t, lowest index first, entries with nothing left skipped
    function automatic void admit_arrivals(logic [FIELD_W-1:0] t);
        int unsigned k;
        for (k = 0; k < entries_in_use(); k++)
            if (arrival_mem[k] == t && left_mem[k] != '0)
                ready_push(k[INDEX_W-1:0]);
    endfunction

    function automatic void predict_tick();
        int unsigned        q;
        int unsigned        k;
        bit                 ran;
        bit                 fin;
        bit                 done;
        logic [INDEX_W-1:0] pid;
        logic [FIELD_W-1:0] start_time;
        logic [FIELD_W-1:0] tat;
        logic [FIELD_W-1:0] wt;
        slot_rec_t          rec;
        q    = (quantum_reg == '0) ? 1 : quantum_reg;
        ran  = 1'b0;
        fin  = 1'b0;
        done = 1'b1;
        pid  = '0;
        tat  = '0;
        wt   = '0;
        // drop a running entry whose burst was cleared by a load
        if (running && left_mem[running_pid] == '0)
            running = 1'b0;
        if (!running && rq_fill != 0)
        begin
            running_pid = ready_pop();
            slice_count = 0;
            running     = (left_mem[running_pid] != '0);
        end
        start_time = sched_clock;
        if (running)
        begin
            ran = 1'b1;
            pid = running_pid;
            left_mem[pid] = left_mem[pid] - 1'b1;
        end
        // clock saturates; arrivals only on a real advance
        if (sched_clock != '1)
        begin
            sched_clock = sched_clock + 1'b1;
            admit_arrivals(sched_clock);
        end
        if (ran)
        begin
            if (left_mem[pid] == '0)
            begin
                fin     = 1'b1;
                running = 1'b0;
                tat = (sched_clock > arrival_mem[pid]) ? sched_clock - arrival_mem[pid] : '0;
                wt  = (tat > burst_mem[pid]) ? tat - burst_mem[pid] : '0;
            end
            else
            begin
                slice_count++;
                if (slice_count >= q)
                begin
                    running = 1'b0;
                    ready_push(pid);
                end
            end
        end
        for (k = 0; k < entries_in_use(); k++)
            if (left_mem[k] != '0)
                done = 1'b0;
        rec.slot_idle    = !ran;
        rec.slot_process = pid;
        rec.slot_time    = start_time;
        rec.finished     = fin;
        rec.turnaround   = tat;
        rec.waiting      = wt;
        rec.all_done     = done;
        expected_slots.push_back(rec);
        predicted_all_done = done;
    endfunction

    function automatic void predict_beat(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx,
                                         logic [FIELD_W-1:0] arr, logic [FIELD_W-1:0] bur);
        int unsigned k;
        case (kind)
            KIND_LOAD:
            begin
                arrival_mem[idx] = arr;
                burst_mem[idx]   = bur;
                left_mem[idx]    = bur;
            end
            KIND_START:
            begin
                for (k = 0; k < entries_in_use(); k++)
                    left_mem[k] = burst_mem[k];
                rq_head     = 0;
                rq_tail     = 0;
                rq_fill     = 0;
                sched_clock = '0;
                running     = 1'b0;
                running_pid = '0;
                slice_count = 0;
                admit_arrivals('0);
            end
            KIND_TICK:
                predict_tick();
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx,
                             input logic [FIELD_W-1:0] arr, input logic [FIELD_W-1:0] bur);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - 2 * FIELD_W - INDEX_W){1'b0}}, bur, arr, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_beat(kind, idx, arr, bur);
        if (kind != KIND_UNUSED)
            beats_sent++;
    endtask

    // tick and start ignore the data fields; keep them random
    task automatic send_tick();
        send_beat(KIND_TICK, INDEX_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
    endtask

    task automatic send_start();
        send_beat(KIND_START, INDEX_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
    endtask

    // hold off until every slot beat is back and the block has gone quiet
    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_slots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_QUANTUM)
            quantum_reg = value[QUANT_W-1:0];
        else
            count_reg = value[COUNT_W-1:0];
        @(posedge clk);
    endtask

    task automatic set_idle_mode(input int gap, input int stall);
        gap_pct   = gap;
        stall_pct = stall;
    endtask

    task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                   input logic [FIELD_W-1:0] want);
        if (error_count < MAX_PRINTS)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Slot beat checker and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        slot_rec_t got;
        slot_rec_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.slot_idle    = m_tuser[0];
            got.finished     = m_tuser[1];
            got.slot_process = m_tdata[3:0];
            got.slot_time    = m_tdata[19:4];
            got.turnaround   = m_tdata[35:20];
            got.waiting      = m_tdata[51:36];
            got.all_done     = m_tdata[52];
            if (expected_slots.size() == 0)
                report_mismatch("slot beat with nothing pending", got.slot_time, '0);
            else
            begin
                want = expected_slots.pop_front();
                if (got.slot_idle !== want.slot_idle)
                    report_mismatch("slot_idle", FIELD_W'(got.slot_idle),
                                    FIELD_W'(want.slot_idle));
                if (got.slot_process !== want.slot_process)
                    report_mismatch("slot_process", FIELD_W'(got.slot_process),
                                    FIELD_W'(want.slot_process));
                if (got.slot_time !== want.slot_time)
                    report_mismatch("slot_time", got.slot_time, want.slot_time);
                if (got.finished !== want.finished)
                    report_mismatch("finished", FIELD_W'(got.finished),
                                    FIELD_W'(want.finished));
                if (got.turnaround !== want.turnaround)
                    report_mismatch("turnaround", got.turnaround, want.turnaround);
                if (got.waiting !== want.waiting)
                    report_mismatch("waiting", got.waiting, want.waiting);
                if (got.all_done !== want.all_done)
                    report_mismatch("all_done", FIELD_W'(got.all_done),
                                    FIELD_W'(want.all_done));
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: ends the run when no beat moves for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] watchdog: no beat for %0d cycles", $realtime, STALL_LIMIT);
        $display("round_robin_time_slice_scheduler verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // ticks with nothing in use, and a kind 3 beat that must be swallowed
    task automatic test_unknown_kind();
        set_idle_mode(0, 0);
        send_tick();
        send_beat(KIND_UNUSED, INDEX_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
        send_tick();
    endtask

    // sixteen arrivals at zero fill the queue; the requeue after the first
    // slice is dropped; a queued entry loaded with zero burst gives an idle tick
    task automatic test_full_queue();
        int k;
        for (k = 0; k < NPROC; k++)
            send_beat(KIND_LOAD, INDEX_W'(k), '0, (k == 0) ? 16'hFFFF : 16'(1 + k % 3));
        drain_block();
        write_reg(REG_QUANTUM, 8'd0);     // acts as one
        write_reg(REG_COUNT, 8'd20);      // clamps to the table size
        send_start();
        send_beat(KIND_LOAD, 4'd15, 16'd1, 16'd1);
        send_tick();
        send_beat(KIND_LOAD, 4'd2, 16'd0, 16'd0);
        repeat (3) send_tick();
    endtask

    // running entry cleared mid-slice is dropped; arrival moved past the
    // finish time makes turnaround and waiting floor at zero
    task automatic test_stale_running();
        drain_block();
        write_reg(REG_QUANTUM, 8'd255);
        write_reg(REG_COUNT, 8'd2);
        send_beat(KIND_LOAD, 4'd0, 16'd0, 16'd5);
        send_beat(KIND_LOAD, 4'd1, 16'd0, 16'd1);
        send_start();
        send_tick();
        send_beat(KIND_LOAD, 4'd0, 16'd0, 16'd0);
        send_beat(KIND_LOAD, 4'd1, 16'd1000, 16'd1);
        repeat (2) send_tick();
    endtask

    // one well-formed schedule with random content and some noise mixed in
    task automatic run_random_schedule();
        int                 n;
        int                 r;
        int                 k;
        int                 ticks;
        int                 extra;
        logic [CFG_DATA_W-1:0] q;
        logic [FIELD_W-1:0] arr;
        logic [FIELD_W-1:0] bur;
        r = $urandom_range(0, 9);
        n = (r == 0) ? 0 : (r == 1) ? NPROC : $urandom_range(1, 8);
        case ($urandom_range(0, 4))
            0:       q = 8'd1;
            1:       q = 8'd2;
            2:       q = CFG_DATA_W'($urandom_range(3, 8));
            3:       q = 8'd255;
            default: q = CFG_DATA_W'($urandom_range(1, 255));
        endcase
        drain_block();
        write_reg(REG_QUANTUM, q);
        write_reg(REG_COUNT, CFG_DATA_W'(n));
        for (k = 0; k < n; k++)
        begin
            bur = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
            send_beat(KIND_LOAD, INDEX_W'(k), FIELD_W'($urandom_range(0, 12)), bur);
        end
        send_start();
        ticks = 0;
        extra = $urandom_range(0, 3);
        while (ticks < TICK_CAP)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                arr = $urandom_range(0, 1) ? 16'($urandom_range(0, 20)) : 16'($urandom);
                bur = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 4)) : 16'($urandom);
                send_beat(KIND_LOAD, INDEX_W'($urandom_range(0, NPROC - 1)), arr, bur);
            end
            else if (r == 4)
                send_beat(KIND_UNUSED, INDEX_W'($urandom), FIELD_W'($urandom),
                          FIELD_W'($urandom));
            else if (r == 5)
                send_start();
            else
            begin
                send_tick();
                ticks++;
                if (predicted_all_done)
                begin
                    if (extra == 0)
                        break;
                    extra--;
                end
            end
        end
    endtask

    task automatic test_random_schedules();
        int mode;
        int target;
        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:       set_idle_mode(0, 0);
                1:       set_idle_mode(45, 0);
                2:       set_idle_mode(0, 45);
                default: set_idle_mode(19, 19);
            endcase
            target = beats_sent + RANDOM_BEATS / 4;
            while (beats_sent < target)
                run_random_schedule();
        end
    endtask

    // one entry arriving late: idle ticks until it is admitted, then it runs
    // alone with a one-unit slice, requeued each time, and finishes unwaited
    task automatic test_late_arrival();
        set_idle_mode(0, 0);
        drain_block();
        write_reg(REG_QUANTUM, 8'd1);
        write_reg(REG_COUNT, 8'd1);
        send_beat(KIND_LOAD, 4'd0, 16'd40, 16'd3);
        send_start();
        repeat (LATE_TICKS) send_tick();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int k;
        for (k = 0; k < NPROC; k++)
        begin
            arrival_mem[k] = '0;
            burst_mem[k]   = '0;
            left_mem[k]    = '0;
            ready_q_mem[k] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unknown_kind();
        test_full_queue();
        test_stale_running();
        test_random_schedules();
        test_late_arrival();

        drain_block();
        if (expected_slots.size() != 0)
            report_mismatch("slot beats never delivered", FIELD_W'(expected_slots.size()),
                            '0);
        if (error_count == 0)
            $display("round_robin_time_slice_scheduler verification clean");
        else
            $display("round_robin_time_slice_scheduler verification failed");
        $finish;
    end

endmodule

/* filelist.f */
design/rrts_pkg.sv
design/round_robin_time_slice_scheduler.sv
test/tb_round_robin_time_slice_scheduler.sv
